/* hdl/lbt_pkg.sv */
package lbt_pkg;

	// table geometry
	localparam int SLOTS  = 16;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = $clog2(SLOTS + 1);

	// field widths
	localparam int OP_W    = 2;
	localparam int IDX_W   = 32;
	localparam int AREA_W  = 8;
	localparam int OFFS_W  = 32;
	localparam int CAP_W   = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_FIND  = 2'd2,
		OP_INVAL = 2'd3
	} op_t;

	// word that walks the row of cells, one cell per cycle while the row is not stalled
	typedef struct packed {
		logic               vld;
		op_t                op;
		logic [CNT_W-1:0]   pos;
		logic [CNT_W-1:0]   cap;
		logic [CNT_W-1:0]   wptr;
		logic               add_en;
		logic [IDX_W-1:0]   index;
		logic [AREA_W-1:0]  entry_area;
		logic [OFFS_W-1:0]  entry_offset;
		logic [AREA_W-1:0]  oldest_area;
		logic               hit;
		logic [IDX_W-1:0]   best_index;
		logic [AREA_W-1:0]  best_area;
		logic [OFFS_W-1:0]  best_offset;
	} token_t;

endpackage

/* hdl/lbt_if.sv */
interface lbt_req_if;
	logic                        valid;
	logic                        ready;
	logic [lbt_pkg::OP_W-1:0]    op;
	logic [lbt_pkg::IDX_W-1:0]   index;
	logic [lbt_pkg::AREA_W-1:0]  entry_area;
	logic [lbt_pkg::OFFS_W-1:0]  entry_offset;
	logic [lbt_pkg::AREA_W-1:0]  oldest_area;

	modport source (output valid, op, index, entry_area, entry_offset, oldest_area,
		input ready);
	modport sink (input valid, op, index, entry_area, entry_offset, oldest_area,
		output ready);
endinterface

interface lbt_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        found;
	logic [lbt_pkg::IDX_W-1:0]   mark_index;
	logic [lbt_pkg::AREA_W-1:0]  mark_area;
	logic [lbt_pkg::OFFS_W-1:0]  mark_offset;

	modport source (output valid, found, mark_index, mark_area, mark_offset,
		input ready);
	modport sink (input valid, found, mark_index, mark_area, mark_offset,
		output ready);
endinterface

/* hdl/log_bookmark_table.sv */
// an item's word is registered in each slot cell and then in the output register before its result shows on rsp
// one item at a time: the word walks the row of slot cells, one cell per cycle unless the row
//   stalls, and the next item enters once its result reaches the output register
// a result waiting on rsp does not block the next item; the row stalls only at its end
// reset: all slots invalid, write pointer zero, capacity 16, no word in flight
module log_bookmark_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [lbt_pkg::CAP_W-1:0]   cfg_wdata,
	lbt_req_if.sink                     req,
	lbt_rsp_if.source                   rsp
);

	logic [lbt_pkg::CAP_W-1:0]   capacity_q;
	logic [lbt_pkg::SLOT_W-1:0]  wptr_q;
	logic                        busy_q;
	logic                        rsp_valid_q;
	logic                        found_q;
	logic [lbt_pkg::IDX_W-1:0]   mark_index_q;
	logic [lbt_pkg::AREA_W-1:0]  mark_area_q;
	logic [lbt_pkg::OFFS_W-1:0]  mark_offset_q;

	logic [lbt_pkg::CNT_W-1:0]   cap_eff;
	logic [lbt_pkg::CNT_W-1:0]   wsel;
	logic [lbt_pkg::CNT_W-1:0]   wnext;
	logic                        accept;
	logic                        en;
	logic                        done;
	lbt_pkg::token_t             tok [lbt_pkg::SLOTS+1];

	assign cap_eff = (32'(capacity_q) > 32'(lbt_pkg::SLOTS)) ?
		lbt_pkg::CNT_W'(lbt_pkg::SLOTS) : lbt_pkg::CNT_W'(capacity_q);

	assign req.ready = !busy_q;
	assign accept    = req.valid && !busy_q;

	// round-robin slot choice for an add
	always_comb begin
		wsel  = (lbt_pkg::CNT_W'(wptr_q) < cap_eff) ? lbt_pkg::CNT_W'(wptr_q) : '0;
		wnext = wsel + lbt_pkg::CNT_W'(1);
		if (wnext >= cap_eff) wnext = '0;
	end

	// row advances unless the finished word cannot leave
	assign en   = !(tok[lbt_pkg::SLOTS].vld && rsp_valid_q && !rsp.ready);
	assign done = en && tok[lbt_pkg::SLOTS].vld;

	// launch word into the first cell
	always_comb begin
		tok[0]              = '0;
		tok[0].vld          = accept;
		tok[0].op           = lbt_pkg::op_t'(req.op);
		tok[0].cap          = cap_eff;
		tok[0].wptr         = wsel;
		tok[0].add_en       = cap_eff != '0;
		tok[0].index        = req.index;
		tok[0].entry_area   = req.entry_area;
		tok[0].entry_offset = req.entry_offset;
		tok[0].oldest_area  = req.oldest_area;
	end

	// row of slot cells
	for (genvar i = 0; i < lbt_pkg::SLOTS; i++) begin : g_cell
		lbt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.tok_i  (tok[i]),
			.tok_o  (tok[i+1])
		);
	end

	// capacity register, write pointer and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lbt_pkg::CAP_RESET;
			wptr_q     <= '0;
			busy_q     <= 1'b0;
		end else begin
			if (cfg_we) capacity_q <= cfg_wdata;
			if (accept) begin
				busy_q <= 1'b1;
				if (lbt_pkg::op_t'(req.op) == lbt_pkg::OP_CLEAR) begin
					wptr_q <= '0;
				end else if (lbt_pkg::op_t'(req.op) == lbt_pkg::OP_ADD && cap_eff != '0) begin
					wptr_q <= lbt_pkg::SLOT_W'(wnext);
				end
			end else if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			found_q       <= tok[lbt_pkg::SLOTS].hit;
			mark_index_q  <= tok[lbt_pkg::SLOTS].best_index;
			mark_area_q   <= tok[lbt_pkg::SLOTS].best_area;
			mark_offset_q <= tok[lbt_pkg::SLOTS].best_offset;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.found       = found_q;
	assign rsp.mark_index  = mark_index_q;
	assign rsp.mark_area   = mark_area_q;
	assign rsp.mark_offset = mark_offset_q;

`ifndef SYNTHESIS
	a_idle_row_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !tok[lbt_pkg::SLOTS].vld)
		else $error("word in flight while idle");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("busy not set after accept");
	a_stall_has_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(tok[lbt_pkg::SLOTS].vld && !en) |-> rsp_valid_q)
		else $error("row stalled with no pending word");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.found) |-> (rsp.mark_index == '0 && rsp.mark_area == '0 &&
		rsp.mark_offset == '0))
		else $error("miss word carries nonzero fields");
`endif

endmodule

/* hdl/lbt_cell.sv */
module lbt_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  lbt_pkg::token_t tok_i,
	output lbt_pkg::token_t tok_o
);

	localparam logic [lbt_pkg::CNT_W-1:0] CNT_ONE = lbt_pkg::CNT_W'(1);

	logic                        valid_q;
	logic [lbt_pkg::IDX_W-1:0]   index_q;
	logic [lbt_pkg::AREA_W-1:0]  area_q;
	logic [lbt_pkg::OFFS_W-1:0]  offset_q;
	lbt_pkg::token_t             tok_q;
	lbt_pkg::token_t             tok_d;
	logic                        in_cap;
	logic                        act;
	logic                        better;

	assign act    = en && tok_i.vld;
	assign in_cap = tok_i.pos < tok_i.cap;

	// closer bookmark: not above the query and strictly above the best so far
	assign better = in_cap && valid_q && (index_q <= tok_i.index) &&
		(!tok_i.hit || (index_q > tok_i.best_index));

	// next word handed to the neighbor
	always_comb begin
		tok_d     = tok_i;
		tok_d.pos = tok_i.pos + CNT_ONE;
		if (tok_i.op == lbt_pkg::OP_FIND && better) begin
			tok_d.hit         = 1'b1;
			tok_d.best_index  = index_q;
			tok_d.best_area   = area_q;
			tok_d.best_offset = offset_q;
		end
	end

	// slot valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (act) begin
			unique case (tok_i.op)
				lbt_pkg::OP_CLEAR: valid_q <= 1'b0;
				lbt_pkg::OP_ADD: begin
					if (tok_i.add_en && tok_i.pos == tok_i.wptr) valid_q <= 1'b1;
				end
				lbt_pkg::OP_INVAL: begin
					if (in_cap && area_q == tok_i.oldest_area) valid_q <= 1'b0;
				end
				default: valid_q <= valid_q;
			endcase
		end
	end

	// slot payload
	always_ff @(posedge clk) begin
		if (act && tok_i.op == lbt_pkg::OP_ADD && tok_i.add_en &&
			tok_i.pos == tok_i.wptr) begin
			index_q  <= tok_i.index;
			area_q   <= tok_i.entry_area;
			offset_q <= tok_i.entry_offset;
		end
	end

	// word register toward the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (en) begin
			tok_q <= tok_d;
		end
	end

	assign tok_o = tok_q;

endmodule
